@@ src/nmeacs_pkg.sv @@
package nmeacs_pkg;

  typedef enum logic [5:0] {
    PH_FIRST = 6'b000001,
    PH_BODY  = 6'b000010,
    PH_HI    = 6'b000100,
    PH_LO    = 6'b001000,
    PH_TAIL  = 6'b010000,
    PH_PASS  = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_TEST = 2'd1,
    MODE_ADD  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_OK        = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_NOSTART   = 3'd3,
    ST_DELIM     = 3'd4,
    ST_UNCHECKED = 3'd5
  } status_t;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharNul    = 8'h00;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h37 + {4'd0, nib};
    end
    return d;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] u;
    if (c >= 8'h61 && c <= 8'h7A) begin
      u = c - 8'd32;
    end else begin
      u = c;
    end
    return u;
  endfunction

endpackage

@@ src/nmea_checksum_check_insert_core.sv @@
// A transfer accepted at a clock edge shows its result at the output register in
// the following cycle; one item per cycle is sustained while the output is not stalled.
// Throughput is set by the combinational XOR and phase update between the input
// and the result register; the input stalls only while a waiting result is stalled.
// Reset (rst_n low, synchronous) clears the output valid, returns the unit to
// waiting for a sentence's first byte and sets the mode register to test mode.
module nmea_checksum_check_insert_core #(
  parameter int MAX_LEN = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_sentence_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_out_byte,
  output logic                       out_keep,
  output logic [2:0]                 out_status,
  output logic [7:0]                 out_checksum_value
);
  import nmeacs_pkg::*;

  localparam logic [7:0] MaxLenC = 8'(MAX_LEN);

  mode_t      cfg_mode_r;
  mode_t      sentence_mode_r, sentence_mode_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic [7:0] byte_position_r, byte_position_nxt;
  logic [7:0] first_hex_char_r, first_hex_char_nxt;
  status_t    sticky_status_r, sticky_status_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       keep_r, keep_nxt;
  status_t    status_r, status_nxt;
  logic [7:0] checksum_r;

  logic       accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    logic       delim_c;
    sentence_mode_nxt  = sentence_mode_r;
    phase_nxt          = phase_r;
    running_xor_nxt    = running_xor_r;
    byte_position_nxt  = byte_position_r;
    first_hex_char_nxt = first_hex_char_r;
    sticky_status_nxt  = sticky_status_r;
    out_byte_nxt       = in_data_byte;
    keep_nxt           = 1'b1;
    status_nxt         = ST_NONE;
    hi_c    = hex_digit(running_xor_r[7:4]);
    lo_c    = hex_digit(running_xor_r[3:0]);
    delim_c = (in_data_byte == CharCr) || (in_data_byte == CharLf) ||
              (in_data_byte == CharNul) || (byte_position_r >= MaxLenC);

    unique case (phase_r)
      PH_FIRST: begin
        sentence_mode_nxt  = (cfg_mode_r == MODE_RSVD) ? MODE_PASS : cfg_mode_r;
        running_xor_nxt    = 8'd0;
        first_hex_char_nxt = 8'd0;
        sticky_status_nxt  = ST_NONE;
        if (sentence_mode_nxt == MODE_PASS) begin
          sticky_status_nxt = ST_UNCHECKED;
          phase_nxt         = PH_PASS;
        end else if (in_data_byte == CharDollar) begin
          phase_nxt = PH_BODY;
        end else begin
          sticky_status_nxt = (sentence_mode_nxt == MODE_ADD) ? ST_OK : ST_NOSTART;
          phase_nxt         = PH_PASS;
        end
      end
      PH_BODY: begin
        if (in_data_byte == CharStar && byte_position_r < MaxLenC) begin
          phase_nxt = PH_HI;
        end else if (delim_c) begin
          sticky_status_nxt = ST_DELIM;
          phase_nxt         = PH_PASS;
        end else begin
          running_xor_nxt = running_xor_r ^ in_data_byte;
        end
      end
      PH_HI: begin
        if (sentence_mode_r == MODE_ADD) begin
          out_byte_nxt = hi_c;
        end else begin
          first_hex_char_nxt = upcase(in_data_byte);
        end
        phase_nxt = PH_LO;
      end
      PH_LO: begin
        if (sentence_mode_r == MODE_ADD) begin
          out_byte_nxt      = lo_c;
          sticky_status_nxt = ST_OK;
        end else if (first_hex_char_r == hi_c && upcase(in_data_byte) == lo_c) begin
          sticky_status_nxt = ST_OK;
        end else begin
          sticky_status_nxt = ST_MISMATCH;
        end
        phase_nxt = PH_TAIL;
      end
      PH_TAIL: begin
        if (sentence_mode_r == MODE_ADD) begin
          keep_nxt = 1'b0;
        end
      end
      PH_PASS: begin
      end
      default: begin
      end
    endcase

    if (byte_position_r != 8'hFF) begin
      byte_position_nxt = byte_position_r + 8'd1;
    end

    if (in_sentence_end) begin
      status_nxt = sticky_status_nxt;
      if (sticky_status_nxt == ST_NONE) begin
        if (phase_nxt == PH_HI || phase_nxt == PH_LO) begin
          status_nxt = (sentence_mode_nxt == MODE_ADD) ? ST_OK : ST_MISMATCH;
        end else begin
          status_nxt = ST_DELIM;
        end
      end
      phase_nxt         = PH_FIRST;
      byte_position_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r       <= MODE_TEST;
      sentence_mode_r  <= MODE_PASS;
      phase_r          <= PH_FIRST;
      running_xor_r    <= 8'd0;
      byte_position_r  <= 8'd0;
      first_hex_char_r <= 8'd0;
      sticky_status_r  <= ST_NONE;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_mode_r <= mode_t'(cfg_wr_data);
      end
      if (accept) begin
        sentence_mode_r  <= sentence_mode_nxt;
        phase_r          <= phase_nxt;
        running_xor_r    <= running_xor_nxt;
        byte_position_r  <= byte_position_nxt;
        first_hex_char_r <= first_hex_char_nxt;
        sticky_status_r  <= sticky_status_nxt;
        out_valid_r      <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r <= out_byte_nxt;
      keep_r     <= keep_nxt;
      status_r   <= status_nxt;
      checksum_r <= running_xor_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_out_byte       = out_byte_r;
  assign out_keep           = keep_r;
  assign out_status         = status_r;
  assign out_checksum_value = checksum_r;

  // A dropped byte can only come from a sentence in insert mode.
  a_keep_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_keep |-> sentence_mode_r == MODE_ADD)
    else $error("byte dropped outside insert mode");

  // Only the last byte of a sentence carries a final status.
  a_status_mid: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_sentence_end |=> out_status == ST_NONE)
    else $error("final status reported before the last byte");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_sentence_end |=> out_status != ST_NONE && phase_r == PH_FIRST)
    else $error("last byte without final status");

  a_unchecked_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNCHECKED |-> sentence_mode_r == MODE_PASS)
    else $error("unchecked status outside pass mode");

endmodule

@@ tb/nmeacs_tb_pkg.sv @@
`timescale 1ns / 100ps
package nmeacs_tb_pkg;
  import nmeacs_pkg::*;

  typedef struct packed {
    logic [7:0] char_out;
    logic       keep;
    status_t    status;
    logic [7:0] xor_sum;
  } char_result_t;

  class sentence_scoreboard;
    int           max_len;
    mode_t        mode_reg;
    mode_t        line_mode;
    phase_t       line_phase;
    logic [7:0]   xor_acc;
    logic [7:0]   char_pos;
    logic [7:0]   rx_hi;
    status_t      outcome;
    char_result_t expected_chars[$];
    int unsigned  errors;

    function new(int max_len_i);
      max_len    = max_len_i;
      mode_reg   = MODE_TEST;
      line_mode  = MODE_PASS;
      line_phase = PH_FIRST;
      xor_acc    = 8'd0;
      char_pos   = 8'd0;
      rx_hi      = 8'd0;
      outcome    = ST_NONE;
      errors     = 0;
    endfunction

    function void set_mode(mode_t m);
      mode_reg = m;
    endfunction

    static function logic [7:0] nibble_char(logic [3:0] n);
      if (n < 4'd10) begin
        return 8'h30 + 8'(n);
      end
      return 8'h41 + 8'(n) - 8'd10;
    endfunction

    static function logic [7:0] to_upper(logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A) begin
        return c & 8'hDF;
      end
      return c;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      char_result_t r;
      logic [7:0]   hi_ch;
      logic [7:0]   lo_ch;
      r.char_out = b;
      r.keep     = 1'b1;
      r.status   = ST_NONE;
      hi_ch      = nibble_char(xor_acc[7:4]);
      lo_ch      = nibble_char(xor_acc[3:0]);
      case (line_phase)
        PH_FIRST: begin
          line_mode = (mode_reg == MODE_RSVD) ? MODE_PASS : mode_reg;
          xor_acc   = 8'd0;
          rx_hi     = 8'd0;
          outcome   = ST_NONE;
          if (line_mode == MODE_PASS) begin
            outcome    = ST_UNCHECKED;
            line_phase = PH_PASS;
          end else if (b == CharDollar) begin
            line_phase = PH_BODY;
          end else begin
            outcome    = (line_mode == MODE_ADD) ? ST_OK : ST_NOSTART;
            line_phase = PH_PASS;
          end
        end
        PH_BODY: begin
          if (b == CharStar && int'(char_pos) < max_len) begin
            line_phase = PH_HI;
          end else if (b == CharCr || b == CharLf || b == CharNul ||
                       int'(char_pos) >= max_len) begin
            outcome    = ST_DELIM;
            line_phase = PH_PASS;
          end else begin
            xor_acc = xor_acc ^ b;
          end
        end
        PH_HI: begin
          if (line_mode == MODE_ADD) begin
            r.char_out = hi_ch;
          end else begin
            rx_hi = to_upper(b);
          end
          line_phase = PH_LO;
        end
        PH_LO: begin
          if (line_mode == MODE_ADD) begin
            r.char_out = lo_ch;
            outcome    = ST_OK;
          end else if (rx_hi == hi_ch && to_upper(b) == lo_ch) begin
            outcome = ST_OK;
          end else begin
            outcome = ST_MISMATCH;
          end
          line_phase = PH_TAIL;
        end
        PH_TAIL: begin
          if (line_mode == MODE_ADD) begin
            r.keep = 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (char_pos != 8'hFF) begin
        char_pos = char_pos + 8'd1;
      end
      if (last) begin
        r.status = outcome;
        if (outcome == ST_NONE) begin
          if (line_phase == PH_HI || line_phase == PH_LO) begin
            r.status = (line_mode == MODE_ADD) ? ST_OK : ST_MISMATCH;
          end else begin
            r.status = ST_DELIM;
          end
        end
        line_phase = PH_FIRST;
        char_pos   = 8'd0;
      end
      r.xor_sum = xor_acc;
      expected_chars.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) begin
        $display("mismatch: %s", msg);
      end
    endtask

    task check_result(logic [7:0] ob, logic kp, logic [2:0] st, logic [7:0] sum);
      char_result_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("output byte %h with no transfer pending", ob));
        return;
      end
      want = expected_chars.pop_front();
      if (ob !== want.char_out) begin
        report_mismatch($sformatf("out_byte %h, predicted %h", ob, want.char_out));
      end
      if (kp !== want.keep) begin
        report_mismatch($sformatf("keep %b, predicted %b", kp, want.keep));
      end
      if (st !== want.status) begin
        report_mismatch($sformatf("status %0d, predicted %0d", st, want.status));
      end
      if (sum !== want.xor_sum) begin
        report_mismatch($sformatf("checksum %h, predicted %h", sum, want.xor_sum));
      end
    endtask
  endclass

endpackage

@@ tb/tb_nmea_checksum_check_insert_core.sv @@
`timescale 1ns / 100ps
module tb_nmea_checksum_check_insert_core;
  import nmeacs_pkg::*;
  import nmeacs_tb_pkg::*;

  localparam int MaxLen     = 128;
  localparam int ItemTarget = 1150;
  localparam int CycleLimit = 300000;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       cfg_wr_en       = 1'b0;
  logic [1:0] cfg_wr_data     = 2'd0;
  logic       in_valid        = 1'b0;
  logic [7:0] in_data_byte    = 8'd0;
  logic       in_sentence_end = 1'b0;
  logic       out_stall       = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_out_byte;
  logic       out_keep;
  logic [2:0] out_status;
  logic [7:0] out_checksum_value;

  bit          quiet       = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  logic [7:0]  line_chars[$];
  sentence_scoreboard sb;

  nmea_checksum_check_insert_core #(
    .MAX_LEN(MaxLen)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_sentence_end   (in_sentence_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_byte      (out_out_byte),
    .out_keep          (out_keep),
    .out_status        (out_status),
    .out_checksum_value(out_checksum_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("nmea_checksum_check_insert_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(out_out_byte, out_keep, out_status, out_checksum_value);
    end
  end

  task automatic send_char(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_sentence_end <= last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_input(b, last);
    items_sent++;
  endtask

  task automatic send_line();
    for (int k = 0; k < line_chars.size(); k++) begin
      send_char(line_chars[k], k == line_chars.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    line_chars.delete();
    for (int k = 0; k < s.len(); k++) begin
      line_chars.push_back(s[k]);
    end
    send_line();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_chars.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_mode(input mode_t m);
    drain();
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_mode(m);
  endtask

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == CharStar || c == CharCr || c == CharLf);
    return c;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] n, input bit lower);
    logic [7:0] c;
    c = sentence_scoreboard::nibble_char(n);
    if (lower && c >= 8'h41) begin
      c = c + 8'd32;
    end
    return c;
  endfunction

  task automatic build_long_line(input int star_pos, input int tail_len);
    logic [7:0] c;
    logic [7:0] sum;
    line_chars.delete();
    line_chars.push_back(CharDollar);
    sum = 8'd0;
    for (int k = 1; k < star_pos; k++) begin
      c   = body_char();
      sum = sum ^ c;
      line_chars.push_back(c);
    end
    line_chars.push_back(CharStar);
    line_chars.push_back(digit_char(sum[7:4], 1'b0));
    line_chars.push_back(digit_char(sum[3:0], 1'b0));
    repeat (tail_len) line_chars.push_back(8'($urandom_range(255)));
  endtask

  task automatic build_line();
    int         pick;
    int         body_len;
    int         tail_kind;
    logic [7:0] c;
    logic [7:0] sum;
    line_chars.delete();
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 8)) line_chars.push_back(8'($urandom_range(255)));
      return;
    end
    line_chars.push_back(CharDollar);
    sum      = 8'd0;
    body_len = $urandom_range(0, 24);
    repeat (body_len) begin
      c   = body_char();
      sum = sum ^ c;
      line_chars.push_back(c);
    end
    if (pick < 14) begin
      case ($urandom_range(2))
        0: line_chars.push_back(CharCr);
        1: line_chars.push_back(CharLf);
        default: line_chars.push_back(CharNul);
      endcase
      repeat ($urandom_range(0, 4)) line_chars.push_back(8'($urandom_range(255)));
      return;
    end
    if (pick < 20) begin
      return;
    end
    line_chars.push_back(CharStar);
    if (pick < 24) begin
      if ($urandom_range(1)) begin
        line_chars.push_back(digit_char(sum[7:4], 1'($urandom_range(1))));
      end
      return;
    end
    line_chars.push_back(digit_char(sum[7:4], 1'($urandom_range(1))));
    line_chars.push_back(digit_char(sum[3:0], 1'($urandom_range(1))));
    if (pick < 34) begin
      line_chars[line_chars.size() - 1 - $urandom_range(1)] = 8'($urandom_range(255));
    end else if (pick < 40) begin
      line_chars[0] = 8'($urandom_range(255));
    end
    tail_kind = $urandom_range(2);
    if (tail_kind == 1) begin
      line_chars.push_back(CharCr);
      line_chars.push_back(CharLf);
    end else if (tail_kind == 2) begin
      repeat ($urandom_range(1, 6)) line_chars.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int    line_no;
    int    roll;
    mode_t next_mode;
    sb = new(MaxLen);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("$A*41");
    send_text("$j*6a");
    send_text("X");
    send_text("$\015");
    send_text("$*");
    send_text("$AB");
    write_mode(MODE_ADD);
    send_text("$A*zz\015\012");
    send_text("Q");
    write_mode(MODE_PASS);
    line_chars = '{8'hFF};
    send_line();
    write_mode(MODE_RSVD);
    line_chars = '{8'h00};
    send_line();

    // The checksum digits land past MAX_LEN and the position counter saturates.
    write_mode(MODE_ADD);
    build_long_line(MaxLen - 1, 140);
    send_line();
    // A star at MAX_LEN arrives too late and counts as a delimiter error.
    write_mode(MODE_TEST);
    build_long_line(MaxLen, 2);
    send_line();

    line_no = 0;
    while (items_sent < ItemTarget) begin
      if (line_no % 6 == 0) begin
        roll = $urandom_range(99);
        if (roll < 45) begin
          next_mode = MODE_TEST;
        end else if (roll < 80) begin
          next_mode = MODE_ADD;
        end else if (roll < 90) begin
          next_mode = MODE_PASS;
        end else begin
          next_mode = MODE_RSVD;
        end
        write_mode(next_mode);
      end
      quiet = (line_no >= 20 && line_no < 35);
      build_line();
      send_line();
      line_no++;
    end
    quiet = 1'b0;

    drain();
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("nmea_checksum_check_insert_core regression: pass");
    end else begin
      $display("nmea_checksum_check_insert_core regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/nmeacs_pkg.sv
src/nmea_checksum_check_insert_core.sv
tb/nmeacs_tb_pkg.sv
tb/tb_nmea_checksum_check_insert_core.sv
